// ===== rtl/core/archive_header_field_parser_core_assert.svh =====
// assertion macros shared by the parser core
`ifndef ARCHIVE_HEADER_FIELD_PARSER_CORE_ASSERT_SVH
`define ARCHIVE_HEADER_FIELD_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define AHFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AHFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ahfp_pkg.sv =====
package ahfp_pkg;

  localparam int unsigned HDR_LEN = 6;
  localparam int unsigned KEY_LEN = 4;
  localparam int unsigned SLEN_LEN = 2;

  localparam logic [31:0] MAGIC_A = 32'h4141_3031;
  localparam logic [31:0] MAGIC_B = 32'h5941_4131;

  localparam logic [2:0] ST_FIELD    = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_MAGIC    = 3'd2;
  localparam logic [2:0] ST_SIZE     = 3'd3;
  localparam logic [2:0] ST_SMALL    = 3'd4;
  localparam logic [2:0] ST_SUBTYPE  = 3'd5;
  localparam logic [2:0] ST_OVERRUN  = 3'd6;
  localparam logic [2:0] ST_TRUNC    = 3'd7;

  localparam logic [2:0] TY_FLAG   = 3'd0;
  localparam logic [2:0] TY_UINT   = 3'd1;
  localparam logic [2:0] TY_BLOB   = 3'd2;
  localparam logic [2:0] TY_HASH   = 3'd3;
  localparam logic [2:0] TY_TIME   = 3'd4;
  localparam logic [2:0] TY_STRING = 3'd5;

  localparam logic [7:0] SUB_FLAG = "*";
  localparam logic [7:0] SUB_U1   = "1";
  localparam logic [7:0] SUB_U2   = "2";
  localparam logic [7:0] SUB_U4   = "4";
  localparam logic [7:0] SUB_U8   = "8";
  localparam logic [7:0] SUB_B2   = "A";
  localparam logic [7:0] SUB_B4   = "B";
  localparam logic [7:0] SUB_B8   = "C";
  localparam logic [7:0] SUB_H4   = "F";
  localparam logic [7:0] SUB_H20  = "G";
  localparam logic [7:0] SUB_H32  = "H";
  localparam logic [7:0] SUB_H48  = "I";
  localparam logic [7:0] SUB_H64  = "J";
  localparam logic [7:0] SUB_T8   = "S";
  localparam logic [7:0] SUB_T12  = "T";
  localparam logic [7:0] SUB_STR  = "P";

  typedef struct packed {
    logic       ok;
    logic [2:0] ftype;
    logic [6:0] len;
  } subtype_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] field_key;
    logic [2:0]  field_type;
    logic [15:0] field_size;
    logic [13:0] field_index;
    logic [15:0] value_offset;
    logic [7:0]  value_byte;
    logic        has_byte;
    logic        field_done;
    logic        last;
  } result_t;

  function automatic subtype_t decode_subtype(input logic [7:0] s);
    subtype_t d;
    d = '{ok: 1'b1, ftype: TY_FLAG, len: 7'd0};
    case (s)
      SUB_FLAG: d = '{ok: 1'b1, ftype: TY_FLAG,   len: 7'd0};
      SUB_U1:   d = '{ok: 1'b1, ftype: TY_UINT,   len: 7'd1};
      SUB_U2:   d = '{ok: 1'b1, ftype: TY_UINT,   len: 7'd2};
      SUB_U4:   d = '{ok: 1'b1, ftype: TY_UINT,   len: 7'd4};
      SUB_U8:   d = '{ok: 1'b1, ftype: TY_UINT,   len: 7'd8};
      SUB_B2:   d = '{ok: 1'b1, ftype: TY_BLOB,   len: 7'd2};
      SUB_B4:   d = '{ok: 1'b1, ftype: TY_BLOB,   len: 7'd4};
      SUB_B8:   d = '{ok: 1'b1, ftype: TY_BLOB,   len: 7'd8};
      SUB_H4:   d = '{ok: 1'b1, ftype: TY_HASH,   len: 7'd4};
      SUB_H20:  d = '{ok: 1'b1, ftype: TY_HASH,   len: 7'd20};
      SUB_H32:  d = '{ok: 1'b1, ftype: TY_HASH,   len: 7'd32};
      SUB_H48:  d = '{ok: 1'b1, ftype: TY_HASH,   len: 7'd48};
      SUB_H64:  d = '{ok: 1'b1, ftype: TY_HASH,   len: 7'd64};
      SUB_T8:   d = '{ok: 1'b1, ftype: TY_TIME,   len: 7'd8};
      SUB_T12:  d = '{ok: 1'b1, ftype: TY_TIME,   len: 7'd12};
      SUB_STR:  d = '{ok: 1'b1, ftype: TY_STRING, len: 7'd0};
      default:  d = '{ok: 1'b0, ftype: TY_FLAG,   len: 7'd0};
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/ahfp_parser.sv =====
`include "archive_header_field_parser_core_assert.svh"

module ahfp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              end_of_buffer,
  output logic              res_valid,
  output ahfp_pkg::result_t res
);

  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_KEY  = 2'd1;
  localparam logic [1:0] PH_SLEN = 2'd2;
  localparam logic [1:0] PH_VAL  = 2'd3;

  logic [15:0] byte_count, byte_count_next;
  logic [15:0] declared_size, declared_size_next;
  logic [1:0]  phase, phase_next;
  logic [31:0] shift_word, shift_word_next;
  logic [23:0] current_key, current_key_next;
  logic [2:0]  current_type, current_type_next;
  logic [15:0] current_size, current_size_next;
  logic [15:0] value_count, value_count_next;
  logic [13:0] field_counter, field_counter_next;
  logic        skipping, skipping_next;

  logic [16:0]        count;
  logic [31:0]        shifted;
  logic [2:0]         err;
  logic               have;
  logic               hdr_ok;
  logic               restart;
  logic               fdone;
  logic [16:0]        vc_inc;
  ahfp_pkg::subtype_t sub;

  // declared bytes left after position pos, compared against thr
  function automatic logic room_below(input logic [15:0] decl, input logic [16:0] pos,
                                      input logic [16:0] thr);
    logic [17:0] diff;
    diff = {2'b00, decl} - {1'b0, pos};
    return !diff[17] && (diff[16:0] < thr);
  endfunction

  assign count   = {1'b0, byte_count} + 17'd1;
  assign shifted = {shift_word[23:0], data_byte};
  assign sub     = ahfp_pkg::decode_subtype(data_byte);
  assign vc_inc  = {1'b0, value_count} + 17'd1;
  assign fdone   = vc_inc >= {1'b0, current_size};

  always_comb begin
    byte_count_next    = byte_count;
    declared_size_next = declared_size;
    phase_next         = phase;
    shift_word_next    = shift_word;
    current_key_next   = current_key;
    current_type_next  = current_type;
    current_size_next  = current_size;
    value_count_next   = value_count;
    field_counter_next = field_counter;
    skipping_next      = skipping;
    err       = ahfp_pkg::ST_FIELD;
    have      = 1'b0;
    hdr_ok    = 1'b0;
    restart   = 1'b0;
    res       = '0;
    res_valid = 1'b0;

    if (skipping) begin
      restart = end_of_buffer;
    end else begin
      byte_count_next = count[15:0];
      case (phase)
        PH_HDR: begin
          shift_word_next = shifted;
          if (count == 17'(4) && shifted != ahfp_pkg::MAGIC_A &&
              shifted != ahfp_pkg::MAGIC_B) begin
            err = ahfp_pkg::ST_MAGIC;
          end
          if (count == 17'(ahfp_pkg::HDR_LEN)) begin
            declared_size_next = {shifted[7:0], shifted[15:8]};
            if (declared_size_next < 16'(ahfp_pkg::HDR_LEN)) begin
              err = ahfp_pkg::ST_SIZE;
            end
            phase_next       = PH_KEY;
            value_count_next = '0;
          end
        end
        PH_KEY: begin
          if (value_count == '0 &&
              room_below(declared_size, {1'b0, byte_count}, 17'(ahfp_pkg::KEY_LEN))) begin
            err = ahfp_pkg::ST_TRUNC;
          end else begin
            shift_word_next  = shifted;
            value_count_next = vc_inc[15:0];
            if (vc_inc == 17'(ahfp_pkg::KEY_LEN)) begin
              current_key_next = shifted[31:8];
              value_count_next = '0;
              if (!sub.ok) begin
                err = ahfp_pkg::ST_SUBTYPE;
              end else begin
                current_type_next = sub.ftype;
                current_size_next = {9'd0, sub.len};
                if (sub.ftype == ahfp_pkg::TY_FLAG) begin
                  have               = 1'b1;
                  field_counter_next = field_counter + 14'd1;
                end else if (sub.ftype == ahfp_pkg::TY_STRING) begin
                  if (room_below(declared_size, count, 17'(ahfp_pkg::SLEN_LEN))) begin
                    err = ahfp_pkg::ST_TRUNC;
                  end else begin
                    phase_next = PH_SLEN;
                  end
                end else if (room_below(declared_size, count, {10'd0, sub.len})) begin
                  err = ahfp_pkg::ST_TRUNC;
                end else begin
                  phase_next = PH_VAL;
                end
              end
            end
          end
        end
        PH_SLEN: begin
          shift_word_next = shifted;
          if (value_count == '0) begin
            value_count_next = 16'd1;
          end else begin
            value_count_next  = '0;
            current_size_next = {shifted[7:0], shifted[15:8]};
            if (room_below(declared_size, count, {1'b0, current_size_next})) begin
              err = ahfp_pkg::ST_OVERRUN;
            end else if (current_size_next == '0) begin
              have               = 1'b1;
              field_counter_next = field_counter + 14'd1;
              phase_next         = PH_KEY;
            end else begin
              phase_next = PH_VAL;
            end
          end
        end
        default: begin
          have             = 1'b1;
          value_count_next = vc_inc[15:0];
          if (fdone) begin
            value_count_next   = '0;
            field_counter_next = field_counter + 14'd1;
            phase_next         = PH_KEY;
          end
        end
      endcase

      if (have) begin
        res.field_key   = current_key_next;
        res.field_type  = current_type_next;
        res.field_size  = current_size_next;
        res.field_index = field_counter;
        if (phase == PH_VAL) begin
          res.value_offset = value_count;
          res.value_byte   = data_byte;
          res.has_byte     = 1'b1;
          res.field_done   = fdone;
        end else begin
          res.field_done = 1'b1;
        end
      end

      if (err == ahfp_pkg::ST_FIELD) begin
        if (count >= 17'(ahfp_pkg::HDR_LEN) && count == {1'b0, declared_size_next}) begin
          if (end_of_buffer) begin
            hdr_ok = 1'b1;
          end else begin
            err = ahfp_pkg::ST_SIZE;
          end
        end else if (end_of_buffer) begin
          err = (count < 17'(ahfp_pkg::HDR_LEN)) ? ahfp_pkg::ST_SMALL : ahfp_pkg::ST_SIZE;
        end
      end

      if (hdr_ok) begin
        res.status = ahfp_pkg::ST_OK;
        res.last   = 1'b1;
        restart    = 1'b1;
      end else if (err != ahfp_pkg::ST_FIELD) begin
        res        = '0;
        res.status = err;
        res.last   = 1'b1;
        restart    = end_of_buffer;
        skipping_next = !end_of_buffer;
      end
      res_valid = fire && (have || hdr_ok || err != ahfp_pkg::ST_FIELD);
    end

    if (restart) begin
      byte_count_next    = '0;
      declared_size_next = '0;
      phase_next         = PH_HDR;
      shift_word_next    = '0;
      current_key_next   = '0;
      current_type_next  = '0;
      current_size_next  = '0;
      value_count_next   = '0;
      field_counter_next = '0;
      skipping_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      declared_size <= '0;
      phase         <= PH_HDR;
      shift_word    <= '0;
      current_key   <= '0;
      current_type  <= '0;
      current_size  <= '0;
      value_count   <= '0;
      field_counter <= '0;
      skipping      <= 1'b0;
    end else if (fire) begin
      byte_count    <= byte_count_next;
      declared_size <= declared_size_next;
      phase         <= phase_next;
      shift_word    <= shift_word_next;
      current_key   <= current_key_next;
      current_type  <= current_type_next;
      current_size  <= current_size_next;
      value_count   <= value_count_next;
      field_counter <= field_counter_next;
      skipping      <= skipping_next;
    end
  end

  `AHFP_ASSERT_NOW(a_err_is_last, res_valid && res.status != ahfp_pkg::ST_FIELD, res.last, "non-data result without last")
  `AHFP_ASSERT_NOW(a_empty_done, res_valid && res.status == ahfp_pkg::ST_FIELD && !res.has_byte, res.field_done, "empty field not marked done")
  `AHFP_ASSERT_NEXT(a_skip_holds, fire && skipping && !end_of_buffer, skipping, "skip mode left before end marker")
  `AHFP_ASSERT_NOW(a_key_count, phase == PH_KEY, value_count < 16'(ahfp_pkg::KEY_LEN), "key byte count out of range")

endmodule

// ===== rtl/core/ahfp_out_reg.sv =====
module ahfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  ahfp_pkg::result_t load_res,
  input  logic              stall,
  output logic              ready,
  output logic              valid,
  output ahfp_pkg::result_t res
);

  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      res <= load_res;
    end
  end

endmodule

// ===== rtl/core/archive_header_field_parser_core.sv =====
// archive header field parser
// input channel (hdr_valid/hdr_stall) takes one header byte per item with
// end_of_buffer set on the final byte of the buffer. output channel
// (res_valid/res_stall) gives at most one result item per input item: a value
// byte tagged with key, type, size, index and offset, an empty-field marker,
// or a status item with last set (header ok or an error code).
// a byte is registered at the input, then parsed in one pass into the
// result register.
// throughput: one byte per cycle unless res_stall holds the result; the header
// state (counts, phase, key) is updated in the same cycle the byte is parsed.
// after an error, bytes produce no items up to and including the end byte.
// reset clears the parser state and the valid flags of both registers; the
// block then expects the magic of a new header.
// when res_stall is high the result holds; a byte already in the input
// register waits there and hdr_stall stays high until the result is taken.
// an empty input register still takes one more byte first.
module archive_header_field_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        hdr_valid,
  output logic        hdr_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic [23:0] field_key,
  output logic [2:0]  field_type,
  output logic [15:0] field_size,
  output logic [13:0] field_index,
  output logic [15:0] value_offset,
  output logic [7:0]  value_byte,
  output logic        has_byte,
  output logic        field_done,
  output logic        last
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              in_end;
  logic              out_ready;
  logic              fire;
  logic              accept;
  logic              step_valid;
  ahfp_pkg::result_t step_res;
  ahfp_pkg::result_t out_res;

  assign fire      = in_full && out_ready;
  assign hdr_stall = in_full && !out_ready;
  assign accept    = hdr_valid && !hdr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= data_byte;
      in_end  <= end_of_buffer;
    end
  end

  ahfp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .data_byte    (in_byte),
    .end_of_buffer(in_end),
    .res_valid    (step_valid),
    .res          (step_res)
  );

  ahfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load_valid(step_valid),
    .load_res  (step_res),
    .stall     (res_stall),
    .ready     (out_ready),
    .valid     (res_valid),
    .res       (out_res)
  );

  assign status       = out_res.status;
  assign field_key    = out_res.field_key;
  assign field_type   = out_res.field_type;
  assign field_size   = out_res.field_size;
  assign field_index  = out_res.field_index;
  assign value_offset = out_res.value_offset;
  assign value_byte   = out_res.value_byte;
  assign has_byte     = out_res.has_byte;
  assign field_done   = out_res.field_done;
  assign last         = out_res.last;

endmodule

// ===== sim/tb_archive_header_field_parser_core.sv =====
module tb_archive_header_field_parser_core;

  localparam int HALF_PERIOD = 5;

  localparam logic [7:0] SUBTYPE_CODES [16] = '{
    ahfp_pkg::SUB_FLAG, ahfp_pkg::SUB_U1, ahfp_pkg::SUB_U2, ahfp_pkg::SUB_U4,
    ahfp_pkg::SUB_U8, ahfp_pkg::SUB_B2, ahfp_pkg::SUB_B4, ahfp_pkg::SUB_B8,
    ahfp_pkg::SUB_H4, ahfp_pkg::SUB_H20, ahfp_pkg::SUB_H32, ahfp_pkg::SUB_H48,
    ahfp_pkg::SUB_H64, ahfp_pkg::SUB_T8, ahfp_pkg::SUB_T12, ahfp_pkg::SUB_STR
  };
  localparam logic [2:0] SUBTYPE_TYPES [16] = '{
    ahfp_pkg::TY_FLAG, ahfp_pkg::TY_UINT, ahfp_pkg::TY_UINT, ahfp_pkg::TY_UINT,
    ahfp_pkg::TY_UINT, ahfp_pkg::TY_BLOB, ahfp_pkg::TY_BLOB, ahfp_pkg::TY_BLOB,
    ahfp_pkg::TY_HASH, ahfp_pkg::TY_HASH, ahfp_pkg::TY_HASH, ahfp_pkg::TY_HASH,
    ahfp_pkg::TY_HASH, ahfp_pkg::TY_TIME, ahfp_pkg::TY_TIME, ahfp_pkg::TY_STRING
  };
  localparam int unsigned SUBTYPE_LENS [16] = '{
    0, 1, 2, 4, 8, 2, 4, 8, 4, 20, 32, 48, 64, 8, 12, 0
  };

  typedef enum logic [1:0] {
    STAGE_PREAMBLE,
    STAGE_KEY,
    STAGE_STRLEN,
    STAGE_VALUE
  } stage_t;

  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_SILENT,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              eob;
    row_kind_t         kind;
    ahfp_pkg::result_t fixed;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        hdr_valid = 1'b0;
  logic        hdr_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_buffer = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [2:0]  status;
  logic [23:0] field_key;
  logic [2:0]  field_type;
  logic [15:0] field_size;
  logic [13:0] field_index;
  logic [15:0] value_offset;
  logic [7:0]  value_byte;
  logic        has_byte;
  logic        field_done;
  logic        last;

  ahfp_pkg::result_t observed;
  ahfp_pkg::result_t due_results [$];
  logic [7:0] frame_q [$];
  stim_row_t opening_rows [$];

  int idle_pct = 22;
  int stall_pct = 22;
  int mismatches = 0;
  int results_checked = 0;
  int sent_items = 0;

  // parser state mirror
  logic [15:0] seen_count;
  logic [15:0] hdr_size;
  logic [31:0] shift_reg;
  logic [23:0] cur_key;
  logic [2:0]  cur_type;
  logic [15:0] cur_size;
  logic [15:0] val_pos;
  logic [13:0] field_no;
  stage_t      stage;
  logic        discarding;

  archive_header_field_parser_core dut (
    .clk(clk),
    .rst(rst),
    .hdr_valid(hdr_valid),
    .hdr_stall(hdr_stall),
    .data_byte(data_byte),
    .end_of_buffer(end_of_buffer),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status(status),
    .field_key(field_key),
    .field_type(field_type),
    .field_size(field_size),
    .field_index(field_index),
    .value_offset(value_offset),
    .value_byte(value_byte),
    .has_byte(has_byte),
    .field_done(field_done),
    .last(last)
  );

  assign observed = '{status: status, field_key: field_key, field_type: field_type,
                      field_size: field_size, field_index: field_index,
                      value_offset: value_offset, value_byte: value_byte,
                      has_byte: has_byte, field_done: field_done, last: last};

  always #HALF_PERIOD clk = ~clk;

  always @(negedge clk) begin
    res_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  function automatic void restart_parse();
    seen_count = '0;
    hdr_size = '0;
    shift_reg = '0;
    cur_key = '0;
    cur_type = ahfp_pkg::TY_FLAG;
    cur_size = '0;
    val_pos = '0;
    field_no = '0;
    stage = STAGE_PREAMBLE;
    discarding = 1'b0;
  endfunction

  function automatic ahfp_pkg::result_t status_item(input logic [2:0] code);
    ahfp_pkg::result_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic ahfp_pkg::result_t field_item(input logic [15:0] offset,
                                                   input logic [7:0] b,
                                                   input logic has, input logic done);
    ahfp_pkg::result_t r;
    r = '0;
    r.status = ahfp_pkg::ST_FIELD;
    r.field_key = cur_key;
    r.field_type = cur_type;
    r.field_size = cur_size;
    r.field_index = field_no;
    r.value_offset = offset;
    r.value_byte = has ? b : 8'h00;
    r.has_byte = has;
    r.field_done = done;
    return r;
  endfunction

  function automatic bit lookup_subtype(input logic [7:0] s, output logic [2:0] ty,
                                        output logic [31:0] len);
    int k;
    ty = ahfp_pkg::TY_FLAG;
    len = '0;
    for (k = 0; k < 16; k++) begin
      if (SUBTYPE_CODES[k] == s) begin
        ty = SUBTYPE_TYPES[k];
        len = SUBTYPE_LENS[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit parse_header_byte(input logic [7:0] b, input logic eob,
                                           output ahfp_pkg::result_t res);
    logic [31:0] count;
    logic [31:0] room;
    logic [31:0] len;
    logic [2:0]  ty;
    logic [2:0]  fail_code;
    bit          failed;
    bit          emit;
    bit          done;
    res = '0;
    failed = 1'b0;
    fail_code = ahfp_pkg::ST_FIELD;
    emit = 1'b0;
    if (discarding) begin
      if (eob) restart_parse();
      return 1'b0;
    end
    count = seen_count + 32'd1;
    seen_count = count[15:0];
    case (stage)
      STAGE_PREAMBLE: begin
        shift_reg = {shift_reg[23:0], b};
        if (count == 4 && shift_reg != ahfp_pkg::MAGIC_A &&
            shift_reg != ahfp_pkg::MAGIC_B) begin
          failed = 1'b1;
          fail_code = ahfp_pkg::ST_MAGIC;
        end
        if (count == ahfp_pkg::HDR_LEN) begin
          hdr_size = {shift_reg[7:0], shift_reg[15:8]};
          if (hdr_size < ahfp_pkg::HDR_LEN) begin
            failed = 1'b1;
            fail_code = ahfp_pkg::ST_SIZE;
          end
          stage = STAGE_KEY;
          val_pos = '0;
        end
      end
      STAGE_KEY: begin
        room = hdr_size - (count - 32'd1);
        if (val_pos == 16'd0 && room < ahfp_pkg::KEY_LEN) begin
          failed = 1'b1;
          fail_code = ahfp_pkg::ST_TRUNC;
        end else begin
          shift_reg = {shift_reg[23:0], b};
          val_pos = val_pos + 16'd1;
          if (val_pos == ahfp_pkg::KEY_LEN) begin
            cur_key = shift_reg[31:8];
            val_pos = '0;
            if (!lookup_subtype(b, ty, len)) begin
              failed = 1'b1;
              fail_code = ahfp_pkg::ST_SUBTYPE;
            end else begin
              cur_type = ty;
              cur_size = len[15:0];
              room = hdr_size - count;
              if (ty == ahfp_pkg::TY_FLAG) begin
                res = field_item(16'd0, 8'h00, 1'b0, 1'b1);
                emit = 1'b1;
                field_no = field_no + 14'd1;
              end else if (ty == ahfp_pkg::TY_STRING) begin
                if (room < ahfp_pkg::SLEN_LEN) begin
                  failed = 1'b1;
                  fail_code = ahfp_pkg::ST_TRUNC;
                end else begin
                  stage = STAGE_STRLEN;
                end
              end else if (room < len) begin
                failed = 1'b1;
                fail_code = ahfp_pkg::ST_TRUNC;
              end else begin
                stage = STAGE_VALUE;
              end
            end
          end
        end
      end
      STAGE_STRLEN: begin
        shift_reg = {shift_reg[23:0], b};
        val_pos = val_pos + 16'd1;
        if (val_pos == ahfp_pkg::SLEN_LEN) begin
          val_pos = '0;
          cur_size = {shift_reg[7:0], shift_reg[15:8]};
          room = hdr_size - count;
          if (room < cur_size) begin
            failed = 1'b1;
            fail_code = ahfp_pkg::ST_OVERRUN;
          end else if (cur_size == 16'd0) begin
            res = field_item(16'd0, 8'h00, 1'b0, 1'b1);
            emit = 1'b1;
            field_no = field_no + 14'd1;
            stage = STAGE_KEY;
          end else begin
            stage = STAGE_VALUE;
          end
        end
      end
      default: begin
        done = ({16'd0, val_pos} + 32'd1) >= {16'd0, cur_size};
        res = field_item(val_pos, b, 1'b1, done);
        emit = 1'b1;
        val_pos = val_pos + 16'd1;
        if (done) begin
          val_pos = '0;
          field_no = field_no + 14'd1;
          stage = STAGE_KEY;
        end
      end
    endcase

    if (!failed) begin
      if (count >= ahfp_pkg::HDR_LEN && count == hdr_size) begin
        if (eob) begin
          res.status = ahfp_pkg::ST_OK;
          res.last = 1'b1;
          restart_parse();
          return 1'b1;
        end
        failed = 1'b1;
        fail_code = ahfp_pkg::ST_SIZE;
      end else if (eob) begin
        failed = 1'b1;
        fail_code = (count < ahfp_pkg::HDR_LEN) ? ahfp_pkg::ST_SMALL : ahfp_pkg::ST_SIZE;
      end
    end

    if (failed) begin
      res = status_item(fail_code);
      if (eob) restart_parse();
      else discarding = 1'b1;
      return 1'b1;
    end
    return emit;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got 'h%0h want 'h%0h",
                                results_checked, name, got, want));
  endtask

  task automatic check_result(input ahfp_pkg::result_t got, input ahfp_pkg::result_t want);
    check_field("status", got.status, want.status);
    check_field("field_key", got.field_key, want.field_key);
    check_field("field_type", got.field_type, want.field_type);
    check_field("field_size", got.field_size, want.field_size);
    check_field("field_index", got.field_index, want.field_index);
    check_field("value_offset", got.value_offset, want.value_offset);
    check_field("value_byte", got.value_byte, want.value_byte);
    check_field("has_byte", got.has_byte, want.has_byte);
    check_field("field_done", got.field_done, want.field_done);
    check_field("last", got.last, want.last);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (due_results.size() == 0)
        report_mismatch($sformatf("result %0d with nothing expected, status %0d",
                                  results_checked, status));
      else
        check_result(observed, due_results.pop_front());
      results_checked++;
    end
  end

  task automatic feed_byte(input logic [7:0] b, input logic eob,
                           input row_kind_t kind = ROW_PREDICTED,
                           input ahfp_pkg::result_t fixed = '0);
    ahfp_pkg::result_t predicted;
    bit produced;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      hdr_valid <= 1'b0;
      @(negedge clk);
    end
    hdr_valid <= 1'b1;
    data_byte <= b;
    end_of_buffer <= eob;
    @(posedge clk);
    while (hdr_stall) @(posedge clk);
    produced = parse_header_byte(b, eob, predicted);
    if (kind == ROW_TYPED) due_results.push_back(fixed);
    else if (kind == ROW_PREDICTED && produced) due_results.push_back(predicted);
    sent_items++;
  endtask

  function automatic stim_row_t mk_row(input logic [7:0] data, input logic eob = 1'b0,
                                       input row_kind_t kind = ROW_PREDICTED,
                                       input ahfp_pkg::result_t fixed = '0);
    stim_row_t r;
    r.data = data;
    r.eob = eob;
    r.kind = kind;
    r.fixed = fixed;
    return r;
  endfunction

  task automatic append_key();
    repeat (3) frame_q.push_back(8'($urandom));
  endtask

  task automatic append_record(input logic [7:0] subtype);
    logic [2:0]  ty;
    logic [31:0] len;
    int unsigned k;
    append_key();
    frame_q.push_back(subtype);
    if (!lookup_subtype(subtype, ty, len)) return;
    if (ty == ahfp_pkg::TY_STRING) begin
      k = $urandom_range(99);
      len = (k < 85) ? $urandom_range(8) :
            (k < 97) ? $urandom_range(9, 40) : $urandom_range(41, 300);
      frame_q.push_back(len[7:0]);
      frame_q.push_back(len[15:8]);
    end
    repeat (len) frame_q.push_back(8'($urandom));
  endtask

  task automatic send_random_header();
    int unsigned mode;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [31:0] magic;
    logic [15:0] size_val;
    frame_q.delete();
    mode = $urandom_range(99);
    if (mode >= 96) begin
      // line noise
      n = $urandom_range(1, 12);
      for (k = 0; k < n; k++)
        feed_byte(8'($urandom), (k == n - 1) || ($urandom_range(7) == 0));
      return;
    end
    magic = $urandom_range(1) ? ahfp_pkg::MAGIC_A : ahfp_pkg::MAGIC_B;
    for (k = 0; k < 4; k++) frame_q.push_back(magic[31 - 8 * k -: 8]);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    n = $urandom_range(0, 3);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(15);
      if (SUBTYPE_LENS[pick] > 12 && $urandom_range(3) != 0) pick = $urandom_range(8);
      append_record(SUBTYPE_CODES[pick]);
    end
    if (mode >= 85 && mode < 91) append_record(8'($urandom));
    if (mode >= 91) begin
      // string length past the declared end
      append_key();
      frame_q.push_back(ahfp_pkg::SUB_STR);
      size_val = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom_range(1, 400));
      frame_q.push_back(size_val[7:0]);
      frame_q.push_back(size_val[15:8]);
    end
    size_val = 16'(frame_q.size());
    if (mode >= 57 && mode < 64)
      size_val = $urandom_range(1) ? 16'($urandom_range(5)) : 16'($urandom);
    if (mode >= 78 && mode < 85 && size_val > 16'd6)
      size_val = 16'($urandom_range(6, size_val - 1));
    frame_q[4] = size_val[7:0];
    frame_q[5] = size_val[15:8];
    if (mode >= 50 && mode < 57) frame_q[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
    if (mode >= 64 && mode < 71) begin
      n = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > n) void'(frame_q.pop_back());
    end
    if (mode >= 71 && mode < 78) repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
    for (k = 0; k < frame_q.size(); k++) feed_byte(frame_q[k], k == frame_q.size() - 1);
  endtask

  initial begin
    ahfp_pkg::result_t flag_ok;
    restart_parse();
    flag_ok = status_item(ahfp_pkg::ST_OK);
    flag_ok.field_key = "key";
    flag_ok.field_type = ahfp_pkg::TY_FLAG;
    flag_ok.field_done = 1'b1;

    opening_rows = '{
      mk_row("Y"), mk_row("A"), mk_row("A"), mk_row("1"), mk_row(8'h06),
      mk_row(8'h00, 1'b1, ROW_TYPED, status_item(ahfp_pkg::ST_OK)),
      mk_row("A"), mk_row("A"), mk_row("0"),
      mk_row("0", 1'b0, ROW_TYPED, status_item(ahfp_pkg::ST_MAGIC)),
      mk_row(8'hff, 1'b1, ROW_SILENT),
      mk_row("A"),
      mk_row("A", 1'b1, ROW_TYPED, status_item(ahfp_pkg::ST_SMALL)),
      mk_row("A"), mk_row("A"), mk_row("0"), mk_row("1"), mk_row(8'h05),
      mk_row(8'h00, 1'b0, ROW_TYPED, status_item(ahfp_pkg::ST_SIZE)),
      mk_row(8'h00, 1'b1, ROW_SILENT),
      mk_row("Y"), mk_row("A"), mk_row("A"), mk_row("1"), mk_row(8'h0a), mk_row(8'h00),
      mk_row("k"), mk_row("e"), mk_row("y"),
      mk_row(ahfp_pkg::SUB_FLAG, 1'b1, ROW_TYPED, flag_ok)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i])
      feed_byte(opening_rows[i].data, opening_rows[i].eob, opening_rows[i].kind,
                opening_rows[i].fixed);

    while (sent_items < 700) begin
      // quiet stretch with both sides always ready
      idle_pct = (sent_items >= 300 && sent_items < 420) ? 0 : 22;
      stall_pct = idle_pct;
      send_random_header();
    end

    @(negedge clk);
    hdr_valid <= 1'b0;
    stall_pct = 22;
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** archive_header_field_parser_core: PASSED **");
    end else begin
      $display("** archive_header_field_parser_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** archive_header_field_parser_core: FAILED **");
    $finish;
  end

endmodule
